/* rtl/core/bmu_pkg.sv */
// Shared types, constants and bit-level helper functions for the bit
// manipulation unit. No dependencies; every other file imports this package.
package bmu_pkg;

   localparam int DATA_W     = 64;
   localparam int OP_W       = 4;
   localparam int AMT_W      = 6;
   localparam int CNT_W      = 7;
   localparam int BYTES      = DATA_W / 8;
   localparam int BYTE_CNT_W = 4;

   typedef enum logic [OP_W-1:0] {
      OP_HIGH_BIT = 4'd0,
      OP_LOW_BIT  = 4'd1,
      OP_CLZ      = 4'd2,
      OP_CTZ      = 4'd3,
      OP_POPCOUNT = 4'd4,
      OP_ROTL     = 4'd5,
      OP_ROTR     = 4'd6,
      OP_BIT_REV  = 4'd7,
      OP_BYTE_REV = 4'd8
   } op_type;

   typedef logic [BYTES-1:0][BYTE_CNT_W-1:0] byte_cnt_type;

   // Travels with each item from stage to stage.
   typedef struct packed {
      logic valid;
      logic is_count;
   } stage_ctl_type;

   // Copies every set bit into all lower positions.
   function automatic logic [DATA_W-1:0] smear_down(input logic [DATA_W-1:0] v);
      logic [DATA_W-1:0] s;
      s = v;
      s = s | (s >> 1);
      s = s | (s >> 2);
      s = s | (s >> 4);
      s = s | (s >> 8);
      s = s | (s >> 16);
      s = s | (s >> 32);
      return s;
   endfunction

   function automatic logic [DATA_W-1:0] bit_reverse(input logic [DATA_W-1:0] v);
      logic [DATA_W-1:0] r;
      for (int i = 0; i < DATA_W; i++) begin
         r[i] = v[DATA_W-1-i];
      end
      return r;
   endfunction

   function automatic logic [DATA_W-1:0] byte_reverse(input logic [DATA_W-1:0] v);
      logic [DATA_W-1:0] r;
      for (int i = 0; i < BYTES; i++) begin
         r[8*i +: 8] = v[8*(BYTES-1-i) +: 8];
      end
      return r;
   endfunction

endpackage

/* rtl/core/bit_manipulation_unit_core.sv */
// Top level of the 64-bit bit manipulation unit: a three-stage pipeline.
// Depends on bmu_pkg, bmu_decode, bmu_count and bmu_merge.
//
// Usage:
// An item is offered on req_type, req_operand and req_rotate_amount with
// req_valid, and is taken at a rising edge where req_valid is high and
// req_stall is low. Each item yields one result on rsp_result with rsp_valid,
// which is taken at an edge where rsp_stall is low.
// One item can be taken every cycle while req_stall is low. The stages are
// decode, per-byte bit count, and the count sum with the output register;
// the 64-bit subtract of the decode stage and the count adder tree set the
// clock period.
// When the receiver stalls, the result is held and the stages behind it
// keep filling; empty stages close up, so req_stall rises only when all
// three stages hold items. Unknown operation codes give a zero result.
// Synchronous reset empties the pipeline; nothing else needs clearing.
module bit_manipulation_unit_core
   import bmu_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [OP_W-1:0]     req_type,
   input  logic [DATA_W-1:0]   req_operand,
   input  logic [AMT_W-1:0]    req_rotate_amount,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [DATA_W-1:0]   rsp_result
);

   stage_ctl_type       s1_ctl, s2_ctl;
   logic [DATA_W-1:0]   s1_direct, s1_src, s2_direct;
   byte_cnt_type        s2_cnt;
   logic                req_ready, s1_ready, s2_ready;

   bmu_decode u_decode (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (req_valid),
      .in_ready      (req_ready),
      .in_op         (req_type),
      .in_operand    (req_operand),
      .in_amount     (req_rotate_amount),
      .out_ctl       (s1_ctl),
      .out_direct    (s1_direct),
      .out_count_src (s1_src),
      .out_ready     (s1_ready)
   );

   bmu_count u_count (
      .clock         (clock),
      .reset         (reset),
      .in_ctl        (s1_ctl),
      .in_ready      (s1_ready),
      .in_direct     (s1_direct),
      .in_count_src  (s1_src),
      .out_ctl       (s2_ctl),
      .out_direct    (s2_direct),
      .out_byte_cnt  (s2_cnt),
      .out_ready     (s2_ready)
   );

   bmu_merge u_merge (
      .clock         (clock),
      .reset         (reset),
      .in_ctl        (s2_ctl),
      .in_ready      (s2_ready),
      .in_direct     (s2_direct),
      .in_byte_cnt   (s2_cnt),
      .out_valid     (rsp_valid),
      .out_result    (rsp_result),
      .out_ready     (!rsp_stall)
   );

   assign req_stall = !req_ready;

   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (s1_ctl.valid && s2_ctl.valid && rsp_valid))
      else $error("input stalled while a pipeline stage is empty");

   a_no_stall_when_drained: assert property (@(posedge clock) disable iff (reset)
      !rsp_stall |-> !req_stall)
      else $error("input stalled although the output is being taken");

   a_stage_advances: assert property (@(posedge clock) disable iff (reset)
      (s1_ctl.valid && s1_ready) |=> s2_ctl.valid)
      else $error("item lost between the decode and count stages");

endmodule

/* rtl/core/bmu_decode.sv */
// First pipeline stage: decodes the operation, produces the direct results
// (isolations, rotates, reversals) and the word whose ones are to be counted.
// Depends on bmu_pkg.
module bmu_decode
   import bmu_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  logic [OP_W-1:0]     in_op,
   input  logic [DATA_W-1:0]   in_operand,
   input  logic [AMT_W-1:0]    in_amount,
   output stage_ctl_type       out_ctl,
   output logic [DATA_W-1:0]   out_direct,
   output logic [DATA_W-1:0]   out_count_src,
   input  logic                out_ready
);

   stage_ctl_type           ctl_ff, ctl_in;
   logic [DATA_W-1:0]       direct_ff, direct_in;
   logic [DATA_W-1:0]       src_ff, src_in;
   logic [DATA_W-1:0]       smear;
   logic [2*DATA_W-1:0]     rotl_wide;
   logic [2*DATA_W-1:0]     rotr_wide;

   assign in_ready = !ctl_ff.valid || out_ready;

   always_comb begin
      smear     = smear_down(in_operand);
      rotl_wide = {in_operand, in_operand} << in_amount;
      rotr_wide = {in_operand, in_operand} >> in_amount;
      direct_in = '0;
      src_in    = '0;
      ctl_in.valid    = in_valid;
      ctl_in.is_count = 1'b0;
      unique case (op_type'(in_op))
         OP_HIGH_BIT: begin
            direct_in = smear & ~(smear >> 1);
         end
         OP_LOW_BIT: begin
            direct_in = in_operand & (~in_operand + DATA_W'(1));
         end
         OP_CLZ: begin
            src_in          = ~smear;
            ctl_in.is_count = 1'b1;
         end
         OP_CTZ: begin
            src_in          = ~in_operand & (in_operand - DATA_W'(1));
            ctl_in.is_count = 1'b1;
         end
         OP_POPCOUNT: begin
            src_in          = in_operand;
            ctl_in.is_count = 1'b1;
         end
         OP_ROTL: begin
            direct_in = rotl_wide[2*DATA_W-1:DATA_W];
         end
         OP_ROTR: begin
            direct_in = rotr_wide[DATA_W-1:0];
         end
         OP_BIT_REV: begin
            direct_in = bit_reverse(in_operand);
         end
         OP_BYTE_REV: begin
            direct_in = byte_reverse(in_operand);
         end
         default: begin
            direct_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else if (in_ready) begin
         ctl_ff <= ctl_in;
      end
      if (in_ready && in_valid) begin
         direct_ff <= direct_in;
         src_ff    <= src_in;
      end
   end

   assign out_ctl       = ctl_ff;
   assign out_direct    = direct_ff;
   assign out_count_src = src_ff;

endmodule

/* rtl/core/bmu_count.sv */
// Second pipeline stage: counts the set bits of each byte of the count word.
// Depends on bmu_pkg.
module bmu_count
   import bmu_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  stage_ctl_type       in_ctl,
   output logic                in_ready,
   input  logic [DATA_W-1:0]   in_direct,
   input  logic [DATA_W-1:0]   in_count_src,
   output stage_ctl_type       out_ctl,
   output logic [DATA_W-1:0]   out_direct,
   output byte_cnt_type        out_byte_cnt,
   input  logic                out_ready
);

   stage_ctl_type       ctl_ff;
   logic [DATA_W-1:0]   direct_ff;
   byte_cnt_type        cnt_ff, cnt_in;

   assign in_ready = !ctl_ff.valid || out_ready;

   always_comb begin
      for (int i = 0; i < BYTES; i++) begin
         cnt_in[i] = BYTE_CNT_W'($countones(in_count_src[8*i +: 8]));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else if (in_ready) begin
         ctl_ff <= in_ctl;
      end
      if (in_ready && in_ctl.valid) begin
         direct_ff <= in_direct;
         cnt_ff    <= cnt_in;
      end
   end

   assign out_ctl      = ctl_ff;
   assign out_direct   = direct_ff;
   assign out_byte_cnt = cnt_ff;

endmodule

/* rtl/core/bmu_merge.sv */
// Final pipeline stage and output register: adds the byte counts and selects
// between the count and the direct result. Depends on bmu_pkg.
module bmu_merge
   import bmu_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  stage_ctl_type       in_ctl,
   output logic                in_ready,
   input  logic [DATA_W-1:0]   in_direct,
   input  byte_cnt_type        in_byte_cnt,
   output logic                out_valid,
   output logic [DATA_W-1:0]   out_result,
   input  logic                out_ready
);

   logic                valid_ff;
   logic [DATA_W-1:0]   result_ff, result_in;
   logic [CNT_W-1:0]    sum;

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      sum = '0;
      for (int i = 0; i < BYTES; i++) begin
         sum = sum + CNT_W'(in_byte_cnt[i]);
      end
      result_in = in_ctl.is_count ? DATA_W'(sum) : in_direct;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_ctl.valid;
      end
      if (in_ready && in_ctl.valid) begin
         result_ff <= result_in;
      end
   end

   assign out_valid  = valid_ff;
   assign out_result = result_ff;

endmodule

/* verif/testbench.sv */
// Self-checking testbench for bit_manipulation_unit_core: a table of directed items, then
// random items under several idling patterns; checked by table answer or local predictor.
// Depends on bmu_pkg and the RTL of bit_manipulation_unit_core.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import bmu_pkg::*;

   localparam logic [OP_W-1:0] OP_UNKNOWN_LO = 4'd9;
   localparam logic [OP_W-1:0] OP_UNKNOWN_HI = 4'd15;
   localparam logic [DATA_W-1:0] ALL_ONES = {DATA_W{1'b1}};
   localparam logic [DATA_W-1:0] TOP_BIT = 64'h8000_0000_0000_0000;
   localparam int NUM_PROBES = 25;
   localparam int ITEMS_PER_PHASE = 210;
   localparam int NUM_PHASES = 5;

   typedef struct packed {
      logic [OP_W-1:0]   code;
      logic [DATA_W-1:0] operand;
      logic [AMT_W-1:0]  amount;
      logic              has_answer;
      logic [DATA_W-1:0] answer;
   } probe_row_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   logic [OP_W-1:0]   req_type = '0;
   logic [DATA_W-1:0] req_operand = '0;
   logic [AMT_W-1:0]  req_rotate_amount = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic [DATA_W-1:0] rsp_result;

   logic [DATA_W-1:0] pending_results [$];
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int items_sent = 0;
   int results_checked = 0;
   int error_count = 0;

   probe_row_type probe_rows [0:NUM_PROBES-1] = '{
      '{OP_HIGH_BIT, 64'h0, 6'd0, 1'b1, 64'h0},
      '{OP_HIGH_BIT, ALL_ONES, 6'd0, 1'b1, TOP_BIT},
      '{OP_HIGH_BIT, 64'h0000_0400_1000_0001, 6'd0, 1'b0, 64'h0},
      '{OP_LOW_BIT, 64'h0, 6'd0, 1'b1, 64'h0},
      '{OP_LOW_BIT, ALL_ONES, 6'd0, 1'b1, 64'h1},
      '{OP_LOW_BIT, 64'h0000_0400_1000_0000, 6'd0, 1'b0, 64'h0},
      '{OP_CLZ, 64'h0, 6'd0, 1'b1, 64'd64},
      '{OP_CLZ, ALL_ONES, 6'd0, 1'b1, 64'd0},
      '{OP_CLZ, 64'h1, 6'd0, 1'b1, 64'd63},
      '{OP_CTZ, 64'h0, 6'd0, 1'b1, 64'd64},
      '{OP_CTZ, TOP_BIT, 6'd0, 1'b1, 64'd63},
      '{OP_CTZ, ALL_ONES, 6'd0, 1'b1, 64'd0},
      '{OP_POPCOUNT, ALL_ONES, 6'd0, 1'b1, 64'd64},
      '{OP_POPCOUNT, 64'h0, 6'd0, 1'b1, 64'd0},
      '{OP_ROTL, 64'h0123_4567_89AB_CDEF, 6'd0, 1'b1, 64'h0123_4567_89AB_CDEF},
      '{OP_ROTL, 64'h8000_0000_0000_0001, 6'd63, 1'b0, 64'h0},
      '{OP_ROTL, 64'h0123_4567_89AB_CDEF, 6'd13, 1'b0, 64'h0},
      '{OP_ROTR, 64'hFEDC_BA98_7654_3210, 6'd0, 1'b1, 64'hFEDC_BA98_7654_3210},
      '{OP_ROTR, 64'h1, 6'd63, 1'b1, 64'h2},
      '{OP_ROTR, 64'hDEAD_BEEF_0F1E_2D3C, 6'd37, 1'b0, 64'h0},
      '{OP_BIT_REV, 64'h1, 6'd0, 1'b1, TOP_BIT},
      '{OP_BIT_REV, 64'h0123_4567_89AB_CDEF, 6'd0, 1'b0, 64'h0},
      '{OP_BYTE_REV, 64'h0102_0304_0506_0708, 6'd0, 1'b1, 64'h0807_0605_0403_0201},
      '{OP_UNKNOWN_LO, ALL_ONES, 6'd63, 1'b1, 64'h0},
      '{OP_UNKNOWN_HI, ALL_ONES, 6'd63, 1'b1, 64'h0}
   };

   bit_manipulation_unit_core dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_type          (req_type),
      .req_operand       (req_operand),
      .req_rotate_amount (req_rotate_amount),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_result        (rsp_result)
   );

   always #10 clock = ~clock;

   function automatic logic [DATA_W-1:0] compute_result(input logic [OP_W-1:0] code,
                                                       input logic [DATA_W-1:0] x,
                                                       input logic [AMT_W-1:0] shift_amt);
      logic [DATA_W-1:0]   r;
      logic [2*DATA_W-1:0] doubled;
      r = '0;
      case (code)
         OP_HIGH_BIT: begin
            for (int i = 0; i < DATA_W; i++) if (x[i]) r = 64'd1 << i;
         end
         OP_LOW_BIT: begin
            for (int i = DATA_W - 1; i >= 0; i--) if (x[i]) r = 64'd1 << i;
         end
         OP_CLZ: begin
            r = DATA_W'(DATA_W);
            for (int i = 0; i < DATA_W; i++) if (x[i]) r = DATA_W'(DATA_W - 1 - i);
         end
         OP_CTZ: begin
            r = DATA_W'(DATA_W);
            for (int i = DATA_W - 1; i >= 0; i--) if (x[i]) r = DATA_W'(i);
         end
         OP_POPCOUNT: begin
            r = DATA_W'($countones(x));
         end
         OP_ROTL: begin
            doubled = {x, x} << shift_amt;
            r = doubled[2*DATA_W-1:DATA_W];
         end
         OP_ROTR: begin
            doubled = {x, x} >> shift_amt;
            r = doubled[DATA_W-1:0];
         end
         OP_BIT_REV: begin
            for (int i = 0; i < DATA_W; i++) r[i] = x[DATA_W-1-i];
         end
         OP_BYTE_REV: begin
            for (int i = 0; i < 8; i++) r[8*i +: 8] = x[8*(7-i) +: 8];
         end
         default: begin
            r = '0;
         end
      endcase
      return r;
   endfunction

   function automatic logic [DATA_W-1:0] pick_operand();
      logic [DATA_W-1:0] v;
      case ($urandom_range(0, 9))
         0: v = '0;
         1: v = ALL_ONES;
         2: v = 64'd1 << $urandom_range(0, 63);
         3: v = ALL_ONES >> $urandom_range(0, 63);
         4: v = ALL_ONES << $urandom_range(0, 63);
         5: v = {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
         6: v = {$urandom, $urandom} | {$urandom, $urandom} | {$urandom, $urandom};
         default: v = {$urandom, $urandom};
      endcase
      return v;
   endfunction

   // Called at a falling edge; returns at the falling edge after the item is taken.
   task automatic send_item(input logic [OP_W-1:0] code, input logic [DATA_W-1:0] operand,
                            input logic [AMT_W-1:0] amount, input logic has_answer,
                            input logic [DATA_W-1:0] answer);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         req_type <= OP_W'($urandom);
         req_operand <= {$urandom, $urandom};
         req_rotate_amount <= AMT_W'($urandom);
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_type <= code;
      req_operand <= operand;
      req_rotate_amount <= amount;
      do @(posedge clock); while (req_stall !== 1'b0);
      pending_results.push_back(has_answer ? answer : compute_result(code, operand, amount));
      items_sent++;
      @(negedge clock);
   endtask

   // Holds the sender back until every outstanding result has been returned.
   task automatic drain_pipeline();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
      @(negedge clock);
   endtask

   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < recv_stall_pct);
   end

   always @(posedge clock) begin
      logic [DATA_W-1:0] want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall == 1'b0) begin
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual %h", $time, rsp_result);
            error_count++;
         end else begin
            want = pending_results.pop_front();
            results_checked++;
            if (rsp_result !== want) begin
               $display("%0t: result mismatch, expected %h, actual %h", $time, want, rsp_result);
               error_count++;
            end
         end
      end
   end

   initial begin
      logic [OP_W-1:0] code;
      logic [AMT_W-1:0] amount;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      for (int i = 0; i < NUM_PROBES; i++) begin
         send_item(probe_rows[i].code, probe_rows[i].operand, probe_rows[i].amount,
                   probe_rows[i].has_answer, probe_rows[i].answer);
      end
      drain_pipeline();

      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         case (phase)
            1: begin send_idle_pct = 74; recv_stall_pct = 0; end
            2: begin send_idle_pct = 0; recv_stall_pct = 74; end
            3: begin send_idle_pct = 22; recv_stall_pct = 22; end
            default: begin send_idle_pct = 0; recv_stall_pct = 0; end
         endcase
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            if ($urandom_range(0, 19) == 0) begin
               code = OP_W'($urandom_range(OP_UNKNOWN_LO, OP_UNKNOWN_HI));
            end else begin
               code = OP_W'($urandom_range(OP_HIGH_BIT, OP_BYTE_REV));
            end
            case ($urandom_range(0, 7))
               0: amount = '0;
               1: amount = '1;
               default: amount = AMT_W'($urandom);
            endcase
            send_item(code, pick_operand(), amount, 1'b0, '0);
         end
         drain_pipeline();
      end

      recv_stall_pct = 0;
      repeat (8) @(posedge clock);
      $display("Sent %0d items and checked %0d results over all nine operations",
               items_sent, results_checked);
      $display("and unknown codes, with no idling, sender gaps, receiver stalls and both.");
      if (error_count == 0) begin
         $display("testbench passed");
      end else begin
         $display("testbench failed");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("testbench failed");
      $finish;
   end
endmodule

/* bit_manipulation_unit_core.f */
rtl/core/bmu_pkg.sv
rtl/core/bmu_decode.sv
rtl/core/bmu_count.sv
rtl/core/bmu_merge.sv
rtl/core/bit_manipulation_unit_core.sv
verif/testbench.sv
